// ----- rtl/dtq_pkg.sv -----
`timescale 1ns / 1ps

package dtq_pkg;

  localparam int QUEUE_DEPTH = 16;

  localparam int FUNC_W = 2;
  localparam int ID_W   = 16;
  localparam int TIME_W = 48;
  localparam int PER_W  = 32;
  localparam int STAT_W = 2;

  localparam int IN_FIELDS_W  = ID_W + TIME_W + PER_W + 1 + TIME_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 1 + ID_W + 1 + TIME_W + STAT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // operation codes carried in in_tuser
  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CANCEL = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_EXPIRE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd2;

  // one timer entry as held by a cell
  typedef struct packed {
    logic              occ;    // slot in use
    logic              fresh;  // rearmed during the current expire pass
    logic              canc;   // cancelled, dropped silently on expiry
    logic              rep;
    logic [PER_W-1:0]  period;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] deadline;
  } entry_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_INSERT,
    OP_POP,
    OP_CANCEL,
    OP_CLRFRESH
  } cell_op_t;

  // broadcast to every cell; ent.id is the key for cancel
  typedef struct packed {
    cell_op_t op;
    entry_t   ent;
  } cell_cmd_t;

endpackage

// ----- rtl/dtq_cell.sv -----
`timescale 1ns / 1ps

// One slot of the sorted queue. Insert shifts right, pop shifts left.
module dtq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  dtq_pkg::cell_cmd_t cmd,
  input  dtq_pkg::entry_t    left_ent,
  input  logic               shift_in,
  input  dtq_pkg::entry_t    right_ent,
  output logic               shift_out,
  input  logic               hit_in,
  output logic               hit_out,
  output dtq_pkg::entry_t    ent
);

  dtq_pkg::entry_t ent_r, ent_nxt;
  logic            match;

  // new entry goes here or earlier: stable order for equal deadlines
  assign shift_out = !ent_r.occ || (ent_r.deadline > cmd.ent.deadline);
  assign match     = ent_r.occ && !ent_r.canc && (ent_r.id == cmd.ent.id);
  assign hit_out   = hit_in | match;
  assign ent       = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    unique case (cmd.op)
      dtq_pkg::OP_INSERT: begin
        if (shift_out) ent_nxt = shift_in ? left_ent : cmd.ent;
      end
      dtq_pkg::OP_POP: begin
        ent_nxt = right_ent;
      end
      dtq_pkg::OP_CANCEL: begin
        if (match && !hit_in) ent_nxt.canc = 1'b1;
      end
      dtq_pkg::OP_CLRFRESH: begin
        ent_nxt.fresh = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.occ   <= 1'b0;
      ent_r.fresh <= 1'b0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

endmodule

// ----- rtl/deadline_timer_queue.sv -----
`timescale 1ns / 1ps

// Channel  Dir  Handshake            Contents
// in_      in   in_tvalid/in_tready  tuser: func; tdata: id, deadline, period, repeat, now
// out_     out  out_tvalid/tready    tdata: fired flag/id, rearm flag/delay, status; tlast
//
// Add and cancel each pass through their own state and a finish state that registers the result
// word. Expire scans the queue head: the cell row pops one expired head entry per cycle while
// the output does not stall, and each repeating entry is reinserted with its rearmed deadline
// before the scan goes on; the first unexpired head ends the scan.
// A new word is taken as soon as the sequencer is idle, even while a result waits.
// A stalled output holds the sequencer whenever it has a word to hand over: the final word
// of any item, and each fired word but the last in an expire.
// Reset (rst_n low, synchronous) empties the queue.
module deadline_timer_queue (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [15:0] event_id, [63:16] deadline, [95:64] period, [96] repeat_req, [144:97] now_ms
  input  logic [dtq_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [1:0] func
  input  logic [dtq_pkg::FUNC_W-1:0]         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] fired_valid, [16:1] fired_id, [17] rearm_valid, [65:18] rearm_delay, [67:66] status
  output logic [dtq_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tlast
);

  localparam int N  = dtq_pkg::QUEUE_DEPTH;
  localparam int TW = dtq_pkg::TIME_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_CANCEL,
    S_SCAN,
    S_REINS,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;

  // latched input word
  logic [dtq_pkg::ID_W-1:0]   id_r, id_nxt;
  logic [TW-1:0]              dl_r, dl_nxt;
  logic [dtq_pkg::PER_W-1:0]  per_r, per_nxt;
  logic                       rep_r, rep_nxt;
  logic [TW-1:0]              now_r, now_nxt;

  logic [dtq_pkg::STAT_W-1:0] status_r, status_nxt;
  logic                       rearm_en_r, rearm_en_nxt;
  // last fired id, held back until we know whether it closes the run
  logic                       hold_v_r, hold_v_nxt;
  logic [dtq_pkg::ID_W-1:0]   hold_id_r, hold_id_nxt;
  dtq_pkg::entry_t            ins_ent_r, ins_ent_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [dtq_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                       out_last_r, out_last_nxt;

  // cell row
  dtq_pkg::cell_cmd_t cmd;
  dtq_pkg::entry_t    cell_ent [N];
  logic [N-1:0]       shift_vec;
  logic [N:0]         hit_vec;
  logic [N-1:0]       occ_vec;
  logic [N-1:0]       fresh_vec;

  assign hit_vec[0] = 1'b0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    dtq_pkg::entry_t left_ent, right_ent;
    logic            left_shift;

    if (i == 0) begin : g_first
      assign left_ent   = '0;
      assign left_shift = 1'b0;
    end else begin : g_mid
      assign left_ent   = cell_ent[i-1];
      assign left_shift = shift_vec[i-1];
    end

    if (i == N - 1) begin : g_last
      assign right_ent = '0;
    end else begin : g_inner
      assign right_ent = cell_ent[i+1];
    end

    dtq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .left_ent  (left_ent),
      .shift_in  (left_shift),
      .right_ent (right_ent),
      .shift_out (shift_vec[i]),
      .hit_in    (hit_vec[i]),
      .hit_out   (hit_vec[i+1]),
      .ent       (cell_ent[i])
    );

    assign occ_vec[i]   = cell_ent[i].occ;
    assign fresh_vec[i] = cell_ent[i].fresh;
  end

  // head of queue
  dtq_pkg::entry_t head;
  logic            expire_hit, head_fires, out_free, can_go, full;
  logic [TW:0]     rearm_sum, delay_diff;
  logic [TW-1:0]   rearm_dl;
  logic            rearm_ok;

  assign head       = cell_ent[0];
  assign full       = occ_vec[N-1];
  // fresh entries sort behind every expired one, so they end the pass
  assign expire_hit = head.occ && !head.fresh && (head.deadline <= now_r);
  assign head_fires = expire_hit && !head.canc;
  assign out_free   = !out_valid_r || out_tready;
  assign can_go     = !(head_fires && hold_v_r) || out_free;

  // now + period, saturated to the time width
  assign rearm_sum  = {1'b0, now_r} + {{(TW + 1 - dtq_pkg::PER_W){1'b0}}, head.period};
  assign rearm_dl   = rearm_sum[TW] ? {TW{1'b1}} : rearm_sum[TW-1:0];
  // borrow clear means deadline >= now
  assign delay_diff = {1'b0, head.deadline} - {1'b0, now_r};
  assign rearm_ok   = rearm_en_r && head.occ && !delay_diff[TW];

  always_comb begin
    cmd = '0;
    cmd.op = dtq_pkg::OP_NOP;
    unique case (state_r)
      S_ADD: begin
        cmd.op           = full ? dtq_pkg::OP_NOP : dtq_pkg::OP_INSERT;
        cmd.ent.occ      = 1'b1;
        cmd.ent.rep      = rep_r;
        cmd.ent.period   = per_r;
        cmd.ent.id       = id_r;
        cmd.ent.deadline = dl_r;
      end
      S_CANCEL: begin
        cmd.op     = dtq_pkg::OP_CANCEL;
        cmd.ent.id = id_r;
      end
      S_SCAN: begin
        if (expire_hit) begin
          cmd.op = can_go ? dtq_pkg::OP_POP : dtq_pkg::OP_NOP;
        end else begin
          cmd.op = dtq_pkg::OP_CLRFRESH;
        end
      end
      S_REINS: begin
        cmd.op  = dtq_pkg::OP_INSERT;
        cmd.ent = ins_ent_r;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    id_nxt        = id_r;
    dl_nxt        = dl_r;
    per_nxt       = per_r;
    rep_nxt       = rep_r;
    now_nxt       = now_r;
    status_nxt    = status_r;
    rearm_en_nxt  = rearm_en_r;
    hold_v_nxt    = hold_v_r;
    hold_id_nxt   = hold_id_r;
    ins_ent_nxt   = ins_ent_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          id_nxt       = in_tdata[15:0];
          dl_nxt       = in_tdata[63:16];
          per_nxt      = in_tdata[95:64];
          rep_nxt      = in_tdata[96];
          now_nxt      = in_tdata[144:97];
          status_nxt   = dtq_pkg::STAT_OK;
          rearm_en_nxt = 1'b0;
          hold_v_nxt   = 1'b0;
          case (in_tuser)
            dtq_pkg::FUNC_ADD: begin
              rearm_en_nxt = 1'b1;
              state_nxt    = S_ADD;
            end
            dtq_pkg::FUNC_CANCEL: state_nxt = S_CANCEL;
            dtq_pkg::FUNC_EXPIRE: begin
              rearm_en_nxt = 1'b1;
              state_nxt    = S_SCAN;
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_ADD: begin
        status_nxt = full ? dtq_pkg::STAT_FULL : dtq_pkg::STAT_OK;
        state_nxt  = S_FIN;
      end
      S_CANCEL: begin
        status_nxt = hit_vec[N] ? dtq_pkg::STAT_OK : dtq_pkg::STAT_NOTFOUND;
        state_nxt  = S_FIN;
      end
      S_SCAN: begin
        if (!expire_hit) begin
          state_nxt = S_FIN;
        end else if (can_go && head_fires) begin
          if (hold_v_r) begin
            // earlier fired id is not the last one: send it now
            out_valid_nxt = 1'b1;
            out_last_nxt  = 1'b0;
            out_data_nxt  = '0;
            out_data_nxt[0]    = 1'b1;
            out_data_nxt[16:1] = hold_id_r;
          end
          hold_v_nxt  = 1'b1;
          hold_id_nxt = head.id;
          if (head.rep) begin
            ins_ent_nxt          = '0;
            ins_ent_nxt.occ      = 1'b1;
            ins_ent_nxt.fresh    = 1'b1;
            ins_ent_nxt.rep      = 1'b1;
            ins_ent_nxt.period   = head.period;
            ins_ent_nxt.id       = head.id;
            ins_ent_nxt.deadline = rearm_dl;
            state_nxt            = S_REINS;
          end
        end
      end
      S_REINS: begin
        state_nxt = S_SCAN;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_last_nxt        = 1'b1;
          out_data_nxt        = '0;
          out_data_nxt[0]     = hold_v_r;
          out_data_nxt[16:1]  = hold_v_r ? hold_id_r : '0;
          out_data_nxt[17]    = rearm_ok;
          out_data_nxt[65:18] = rearm_ok ? delay_diff[TW-1:0] : '0;
          out_data_nxt[67:66] = status_r;
          hold_v_nxt          = 1'b0;
          state_nxt           = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    id_r       <= id_nxt;
    dl_r       <= dl_nxt;
    per_r      <= per_nxt;
    rep_r      <= rep_nxt;
    now_r      <= now_nxt;
    status_r   <= status_nxt;
    rearm_en_r <= rearm_en_nxt;
    hold_id_r  <= hold_id_nxt;
    ins_ent_r  <= ins_ent_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // occupied slots always form a prefix of the row
  a_occ_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_vec & ~{occ_vec[N-2:0], 1'b1}) == '0)
    else $error("occupied slots not contiguous");

  // a reinsert always follows a pop, so there is room
  a_reins_room: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_REINS |-> !full)
    else $error("reinsert into full queue");

  // rearm marks never outlive an expire pass
  a_fresh_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> fresh_vec == '0)
    else $error("fresh mark left after expire");

  // no held fired id between items
  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !hold_v_r)
    else $error("held fired id leaked past item end");

endmodule
